>>> src/bmirq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package bmirq_pkg;

    // bus operation codes
    localparam logic [2:0] OP_REG_WRITE = 3'd0;
    localparam logic [2:0] OP_TICK      = 3'd1;
    localparam logic [2:0] OP_PRG_MAP   = 3'd2;
    localparam logic [2:0] OP_CHR_MAP   = 3'd3;
    localparam logic [2:0] OP_NT_MAP    = 3'd4;
    localparam logic [2:0] OP_RAM_READ  = 3'd5;
    localparam logic [2:0] OP_RAM_WRITE = 3'd6;

    // register groups, addr bits 15:12
    localparam logic [3:0] GRP_PRG01 = 4'h8;
    localparam logic [3:0] GRP_PRG2  = 4'h9;
    localparam logic [3:0] GRP_CHR01 = 4'ha;
    localparam logic [3:0] GRP_CHR23 = 4'hb;
    localparam logic [3:0] GRP_CHR45 = 4'hc;
    localparam logic [3:0] GRP_CHR67 = 4'hd;
    localparam logic [3:0] GRP_RELOAD = 4'he;
    localparam logic [3:0] GRP_IRQ   = 4'hf;

    // register selects within a group, addr bits 1:0
    localparam logic [1:0] SEL_IRQ_ACK  = 2'd0;
    localparam logic [1:0] SEL_IRQ_CTRL = 2'd1;
    localparam logic [1:0] SEL_MIRROR   = 2'd2;
    localparam logic [1:0] SEL_RAM_CTRL = 2'd2;

    // nametable mirroring modes
    localparam logic [1:0] MIR_HORZ   = 2'd0;
    localparam logic [1:0] MIR_VERT   = 2'd1;
    localparam logic [1:0] MIR_SCREEN0 = 2'd2;
    localparam logic [1:0] MIR_SCREEN1 = 2'd3;

    // counter width masks
    localparam logic [15:0] MASK_4  = 16'h000f;
    localparam logic [15:0] MASK_8  = 16'h00ff;
    localparam logic [15:0] MASK_12 = 16'h0fff;
    localparam logic [15:0] MASK_16 = 16'hffff;

    localparam logic [7:0] PRG_FIXED_BANK = 8'hff;

    // bank and mirroring state seen by the translator
    typedef struct packed {
        logic [2:0][7:0] prg_bank;
        logic [7:0][7:0] chr_bank;
        logic [1:0]      mirror_mode;
        logic            ram_enable;
        logic            ram_write_enable;
    } t_map_state;

    function automatic logic [7:0] set_nibble(input logic [7:0] old_val,
                                              input logic [3:0] nib,
                                              input logic       high);
        logic [7:0] res;
        res = high ? {nib, old_val[3:0]} : {old_val[7:4], nib};
        return res;
    endfunction

endpackage

`default_nettype wire

>>> src/bmirq_if.sv
`timescale 1ns / 1ps
`default_nettype none

// bus item channel
interface bmirq_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  op;
    logic [15:0] addr;
    logic [7:0]  data;

    modport source (output valid, output op, output addr, output data, input ready);
    modport sink   (input valid, input op, input addr, input data, output ready);
endinterface

// result channel
interface bmirq_out_if;
    logic        valid;
    logic        ready;
    logic [20:0] mapped_addr;
    logic        access_ok;
    logic        irq_out;

    modport source (output valid, output mapped_addr, output access_ok, output irq_out,
                    input ready);
    modport sink   (input valid, input mapped_addr, input access_ok, input irq_out,
                    output ready);
endinterface

`default_nettype wire

>>> src/bmirq_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module bmirq_regs
    import bmirq_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_proc,
    input  wire logic [2:0]  i_op,
    input  wire logic [15:0] i_addr,
    input  wire logic [7:0]  i_data,
    output t_map_state       o_state,
    output logic             o_irq_next
);

    t_map_state  r_state, n_state;
    logic [15:0] r_irq_count, n_irq_count;
    logic [15:0] r_irq_reload, n_irq_reload;
    logic        r_irq_enable, n_irq_enable;
    logic [15:0] r_irq_mask, n_irq_mask;
    logic        r_irq_line, n_irq_line;

    logic [3:0]  grp;
    logic [1:0]  lo;
    logic [3:0]  nib;
    logic [2:0]  chr_idx;
    logic [15:0] dec_count;

    assign grp       = i_addr[15:12];
    assign lo        = i_addr[1:0];
    assign nib       = i_data[3:0];
    assign chr_idx   = {grp[1:0] + 2'd2, lo[1]};
    assign dec_count = (r_irq_count & ~r_irq_mask) | ((r_irq_count - 16'd1) & r_irq_mask);

    // register writes and counter tick
    always_comb begin
        n_state      = r_state;
        n_irq_count  = r_irq_count;
        n_irq_reload = r_irq_reload;
        n_irq_enable = r_irq_enable;
        n_irq_mask   = r_irq_mask;
        n_irq_line   = r_irq_line;
        if (i_proc && i_op == OP_REG_WRITE) begin
            unique case (grp) inside
                GRP_PRG01: begin
                    n_state.prg_bank[lo[1]] = set_nibble(r_state.prg_bank[lo[1]], nib, lo[0]);
                end
                GRP_PRG2: begin
                    if (!lo[1]) begin
                        n_state.prg_bank[2] = set_nibble(r_state.prg_bank[2], nib, lo[0]);
                    end else if (lo == SEL_RAM_CTRL) begin
                        n_state.ram_enable       = nib[0];
                        n_state.ram_write_enable = nib[1];
                    end
                end
                GRP_CHR01, GRP_CHR23, GRP_CHR45, GRP_CHR67: begin
                    n_state.chr_bank[chr_idx] = set_nibble(r_state.chr_bank[chr_idx], nib, lo[0]);
                end
                GRP_RELOAD: begin
                    case (lo)
                        2'd0:    n_irq_reload[3:0]   = nib;
                        2'd1:    n_irq_reload[7:4]   = nib;
                        2'd2:    n_irq_reload[11:8]  = nib;
                        default: n_irq_reload[15:12] = nib;
                    endcase
                end
                GRP_IRQ: begin
                    if (lo == SEL_IRQ_ACK) begin
                        n_irq_line  = 1'b0;
                        n_irq_count = r_irq_reload;
                    end else if (lo == SEL_IRQ_CTRL) begin
                        n_irq_line   = 1'b0;
                        n_irq_enable = nib[0];
                        if (nib[3])      n_irq_mask = MASK_4;
                        else if (nib[2]) n_irq_mask = MASK_8;
                        else if (nib[1]) n_irq_mask = MASK_12;
                        else             n_irq_mask = MASK_16;
                    end else if (lo == SEL_MIRROR) begin
                        n_state.mirror_mode = nib[1:0];
                    end
                end
                default: ;
            endcase
        end else if (i_proc && i_op == OP_TICK && r_irq_enable) begin
            n_irq_count = dec_count;
            if ((dec_count & r_irq_mask) == r_irq_mask) begin
                n_irq_line = 1'b1;
            end
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= '0;
            r_irq_count  <= '0;
            r_irq_reload <= '0;
            r_irq_enable <= 1'b0;
            r_irq_mask   <= MASK_16;
            r_irq_line   <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_irq_count  <= n_irq_count;
            r_irq_reload <= n_irq_reload;
            r_irq_enable <= n_irq_enable;
            r_irq_mask   <= n_irq_mask;
            r_irq_line   <= n_irq_line;
        end
    end

    assign o_state    = r_state;
    assign o_irq_next = n_irq_line;

endmodule

`default_nettype wire

>>> src/bmirq_xlate.sv
`timescale 1ns / 1ps
`default_nettype none

module bmirq_xlate
    import bmirq_pkg::*;
(
    input  wire logic [2:0]  i_op,
    input  wire logic [15:0] i_addr,
    input  wire t_map_state  i_state,
    output logic [20:0]      o_mapped_addr,
    output logic             o_access_ok
);

    logic [7:0] prg_sel;
    logic [7:0] chr_sel;
    logic       nt_bit;

    // prg window bank, top window fixed
    always_comb begin
        case (i_addr[14:13])
            2'd0:    prg_sel = i_state.prg_bank[0];
            2'd1:    prg_sel = i_state.prg_bank[1];
            2'd2:    prg_sel = i_state.prg_bank[2];
            default: prg_sel = PRG_FIXED_BANK;
        endcase
    end

    assign chr_sel = i_state.chr_bank[i_addr[12:10]];

    // nametable page bit
    always_comb begin
        case (i_state.mirror_mode)
            MIR_HORZ:    nt_bit = i_addr[11];
            MIR_VERT:    nt_bit = i_addr[10];
            MIR_SCREEN0: nt_bit = 1'b0;
            default:     nt_bit = 1'b1;
        endcase
    end

    // translation per operation
    always_comb begin
        o_mapped_addr = '0;
        o_access_ok   = 1'b0;
        unique case (i_op)
            OP_PRG_MAP:   o_mapped_addr = {prg_sel, i_addr[12:0]};
            OP_CHR_MAP:   o_mapped_addr = {3'd0, chr_sel, i_addr[9:0]};
            OP_NT_MAP:    o_mapped_addr = {10'd0, nt_bit, i_addr[9:0]};
            OP_RAM_READ: begin
                o_mapped_addr = {8'd0, i_addr[12:0]};
                o_access_ok   = i_state.ram_enable;
            end
            OP_RAM_WRITE: begin
                o_mapped_addr = {8'd0, i_addr[12:0]};
                o_access_ok   = i_state.ram_enable & i_state.ram_write_enable;
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

>>> src/bank_mapper_with_irq_counter_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Cartridge bank mapper with a maskable IRQ down-counter. Each bus word (register
// write, CPU tick, PRG/CHR/nametable translation, work RAM read or write) gives
// exactly one result word carrying the translated address, the RAM access flag and
// the IRQ level after that word. One word is taken every clock while the result
// register is not stalled; words pass the input register, then the result register,
// strictly in order, each seeing the bank and counter state left by the word before.
module bank_mapper_with_irq_counter_unit
    import bmirq_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    bmirq_in_if.sink     i_item,
    bmirq_out_if.source  o_res
);

    logic        r_s1_valid;
    logic [2:0]  r_s1_op;
    logic [15:0] r_s1_addr;
    logic [7:0]  r_s1_data;

    logic        r_out_valid;
    logic [20:0] r_out_mapped;
    logic        r_out_ok;
    logic        r_out_irq;

    logic        s1_adv;
    logic        s1_proc;
    t_map_state  map_state;
    logic        irq_next;
    logic [20:0] mapped_addr;
    logic        access_ok;

    // pipeline flow
    assign s1_adv       = !r_out_valid || o_res.ready;
    assign s1_proc      = r_s1_valid && s1_adv;
    assign i_item.ready = !r_s1_valid || s1_adv;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_s1_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.ready && i_item.valid) begin
            r_s1_op   <= i_item.op;
            r_s1_addr <= i_item.addr;
            r_s1_data <= i_item.data;
        end
    end

    bmirq_regs u_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_proc     (s1_proc),
        .i_op       (r_s1_op),
        .i_addr     (r_s1_addr),
        .i_data     (r_s1_data),
        .o_state    (map_state),
        .o_irq_next (irq_next)
    );

    bmirq_xlate u_xlate (
        .i_op          (r_s1_op),
        .i_addr        (r_s1_addr),
        .i_state       (map_state),
        .o_mapped_addr (mapped_addr),
        .o_access_ok   (access_ok)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_proc) begin
            r_out_mapped <= mapped_addr;
            r_out_ok     <= access_ok;
            r_out_irq    <= irq_next;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.mapped_addr = r_out_mapped;
    assign o_res.access_ok   = r_out_ok;
    assign o_res.irq_out     = r_out_irq;

endmodule

`default_nettype wire
